// File: sv/tuip_pkg.sv
`default_nettype none

package tuip_pkg;

  // Default sizes handed to the top level.
  localparam int unsigned WORD_BITS_DEF  = 64;
  localparam int unsigned INDEX_BITS_DEF = 16;

  // Width of the base register and of a digit value.
  localparam int unsigned BASE_BITS = 6;

  // Output width of the stop index, fixed by the interface.
  localparam int unsigned STOP_BITS = 16;

  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

  // Digit value given to a byte that is no digit in any base.
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = 6'd63;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_X  = 8'h58;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5a;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_X  = 8'h78;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7a;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_FIRST  = 3'd1,
    PH_ZERO   = 3'd2,
    PH_ZEROX  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_SKIP   = 3'd5,
    PH_BAD    = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_DIGITS = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_BAD_BASE  = 2'd3
  } status_e;

  // Value of a byte as a digit in bases up to 36; DIGIT_NONE otherwise.
  function automatic logic [BASE_BITS-1:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'(c - CHAR_LO_A + 8'd10);
    if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
      return v[BASE_BITS-1:0];
    end
    v = 8'(c - CHAR_UP_A + 8'd10);
    if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
      return v[BASE_BITS-1:0];
    end
    v = 8'(c - CHAR_ZERO);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return v[BASE_BITS-1:0];
    end
    return DIGIT_NONE;
  endfunction

endpackage

`default_nettype wire

// File: sv/tuip_mac.sv
`default_nettype none

// Multiply-accumulate step: acc * base + digit, with a flag when the
// result no longer fits in WORD_BITS bits.
module tuip_mac #(
  parameter int unsigned WORD_BITS = tuip_pkg::WORD_BITS_DEF
) (
  input  wire logic [WORD_BITS-1:0]           acc_i,
  input  wire logic [tuip_pkg::BASE_BITS-1:0] base_i,
  input  wire logic [tuip_pkg::BASE_BITS-1:0] digit_i,
  output logic      [WORD_BITS-1:0]           acc_o,
  output logic                                overflow_o
);

  localparam int unsigned PW = WORD_BITS + tuip_pkg::BASE_BITS;

  logic [PW-1:0] prod;

  // The sum stays below 2^PW since both base and digit are under 64.
  assign prod       = PW'(acc_i) * PW'(base_i) + PW'(digit_i);
  assign acc_o      = prod[WORD_BITS-1:0];
  assign overflow_o = |prod[PW-1:WORD_BITS];

endmodule

`default_nettype wire

// File: sv/text_to_unsigned_integer_parser_unit.sv
// Streaming text-to-unsigned-integer converter in the manner of strtoul. One
// byte of a NUL-terminated string is taken per input transfer. Leading white
// space is skipped, one optional sign is taken, and digits in the base held by
// number_base_i are accumulated (0 auto-detects octal, decimal or hex; a 0x
// prefix counts only if a hex digit follows it). The NUL byte produces exactly
// one output transfer carrying the value, the index of the first unconsumed
// byte and a status; every other byte produces none. The block takes one byte
// per clock cycle while no NUL is held for the output register. The figure is
// set by the accumulator loop: a 64-by-6-bit multiply-add whose result is fed
// back for the next byte. A byte passes through an input register and then
// updates the parse state; the result of a NUL is loaded into the output
// register when the NUL leaves the input register. Bytes other than NUL keep
// flowing while a result waits to be taken; a second NUL waits in the input
// register, and holds off the input, until the output register is free.
// number_base_i is sampled on the first byte of each string and should only
// be written while the block is idle.

`default_nettype none

module text_to_unsigned_integer_parser_unit #(
  parameter int unsigned WORD_BITS  = tuip_pkg::WORD_BITS_DEF,
  parameter int unsigned INDEX_BITS = tuip_pkg::INDEX_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [tuip_pkg::BASE_BITS-1:0]     number_base_i,

  // Character input channel.
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [7:0]                         character_i,

  // Result output channel.
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [WORD_BITS-1:0]               value_o,
  output logic      [tuip_pkg::STOP_BITS-1:0]     stop_index_o,
  output logic      [1:0]                         status_o
);

  localparam int unsigned BB = tuip_pkg::BASE_BITS;
  localparam int unsigned SB = tuip_pkg::STOP_BITS;

  // ---------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------
  logic [BB-1:0] number_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= tuip_pkg::BASE_AUTO;
    end else if (cfg_we_i) begin
      number_base_q <= number_base_i;
    end
  end

  // ---------------------------------------------------------------------
  // Input register. A held byte is consumed when it is not NUL, or when
  // the output register can take the result that a NUL produces.
  // ---------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       out_free;
  logic       is_nul;
  logic       fire;

  assign is_nul     = (char_q == tuip_pkg::CHAR_NUL);
  assign out_free   = !out_valid_o || out_ready_i;
  assign fire       = in_valid_q && (!is_nul || out_free);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= character_i;
    end
  end

  // ---------------------------------------------------------------------
  // Parse state.
  // ---------------------------------------------------------------------
  tuip_pkg::phase_e      phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic                  ovf_q, ovf_d;
  logic [WORD_BITS-1:0]  acc_q, acc_d;
  logic [BB-1:0]         base_q, base_d;
  logic [INDEX_BITS-1:0] pos_q, pos_d;
  logic [INDEX_BITS-1:0] stop_q, stop_d;
  logic                  seen_q, seen_d;

  // The base register is sampled on the first byte of a string; a base
  // outside 2..36 (other than auto) sends the string to the bad phase.
  logic             first_byte;
  logic             base_bad;
  logic [BB-1:0]    base_eff;
  tuip_pkg::phase_e phase_eff;

  assign first_byte = (pos_q == '0) && (phase_q == tuip_pkg::PH_SPACE);
  assign base_bad   = (number_base_q != tuip_pkg::BASE_AUTO) &&
                      ((number_base_q < tuip_pkg::BASE_MIN) ||
                       (number_base_q > tuip_pkg::BASE_MAX));
  assign base_eff   = first_byte ? number_base_q : base_q;
  assign phase_eff  = (first_byte && base_bad) ? tuip_pkg::PH_BAD : phase_q;

  // Saturating index of the byte after this one.
  logic [INDEX_BITS-1:0] pos_next;
  assign pos_next = (pos_q == '1) ? pos_q : pos_q + 1'b1;

  logic [BB-1:0] digit;
  assign digit = tuip_pkg::digit_value(char_q);

  // Base in which a digit is taken. Auto base turns into decimal on a
  // first byte that is not '0'; after 0x the base becomes hex.
  logic [BB-1:0] take_base;
  always_comb begin
    if (phase_eff == tuip_pkg::PH_ZEROX) begin
      take_base = tuip_pkg::BASE_HEX;
    end else if (base_eff == tuip_pkg::BASE_AUTO) begin
      take_base = tuip_pkg::BASE_DEC;
    end else begin
      take_base = base_eff;
    end
  end

  logic [WORD_BITS-1:0] mac_acc;
  logic                 mac_ovf;

  tuip_mac #(
    .WORD_BITS (WORD_BITS)
  ) u_mac (
    .acc_i      (acc_q),
    .base_i     (take_base),
    .digit_i    (digit),
    .acc_o      (mac_acc),
    .overflow_o (mac_ovf)
  );

  logic is_space;
  logic is_x;
  logic do_take;
  logic do_first;

  assign is_space = (char_q == tuip_pkg::CHAR_SPACE) ||
                    ((char_q >= tuip_pkg::CHAR_TAB) && (char_q <= tuip_pkg::CHAR_CR));
  assign is_x     = (char_q == tuip_pkg::CHAR_LO_X) || (char_q == tuip_pkg::CHAR_UP_X);

  always_comb begin
    phase_d  = phase_eff;
    neg_d    = neg_q;
    ovf_d    = ovf_q;
    acc_d    = acc_q;
    base_d   = base_eff;
    pos_d    = pos_next;
    stop_d   = stop_q;
    seen_d   = seen_q;
    do_take  = 1'b0;
    do_first = 1'b0;

    unique case (phase_eff)
      tuip_pkg::PH_SPACE: begin
        if (is_space) begin
          // Leading white space is skipped.
        end else if (char_q == tuip_pkg::CHAR_MINUS) begin
          neg_d   = 1'b1;
          phase_d = tuip_pkg::PH_FIRST;
        end else if (char_q == tuip_pkg::CHAR_PLUS) begin
          phase_d = tuip_pkg::PH_FIRST;
        end else begin
          do_first = 1'b1;
        end
      end
      tuip_pkg::PH_FIRST: begin
        do_first = 1'b1;
      end
      tuip_pkg::PH_ZERO: begin
        if (is_x) begin
          phase_d = tuip_pkg::PH_ZEROX;
        end else begin
          do_take = 1'b1;
        end
      end
      tuip_pkg::PH_ZEROX: begin
        if (digit < tuip_pkg::BASE_HEX) begin
          base_d  = tuip_pkg::BASE_HEX;
          do_take = 1'b1;
        end else begin
          phase_d = tuip_pkg::PH_SKIP;
        end
      end
      tuip_pkg::PH_DIGITS: begin
        do_take = 1'b1;
      end
      default: begin
        // Skip and bad-base phases ignore bytes up to the NUL.
      end
    endcase

    // A leading '0' in auto or hex base may open a 0x prefix.
    if (do_first) begin
      if ((char_q == tuip_pkg::CHAR_ZERO) &&
          ((base_eff == tuip_pkg::BASE_AUTO) || (base_eff == tuip_pkg::BASE_HEX))) begin
        if (base_eff == tuip_pkg::BASE_AUTO) begin
          base_d = tuip_pkg::BASE_OCT;
        end
        seen_d  = 1'b1;
        stop_d  = pos_next;
        phase_d = tuip_pkg::PH_ZERO;
      end else begin
        base_d  = take_base;
        do_take = 1'b1;
      end
    end

    // A byte that is no digit in the base ends the number. Overflow is
    // sticky and freezes the accumulator.
    if (do_take) begin
      if (digit >= take_base) begin
        phase_d = tuip_pkg::PH_SKIP;
      end else begin
        if (!ovf_q) begin
          if (mac_ovf) begin
            ovf_d = 1'b1;
          end else begin
            acc_d = mac_acc;
          end
        end
        seen_d  = 1'b1;
        stop_d  = pos_next;
        phase_d = tuip_pkg::PH_DIGITS;
      end
    end

    // The NUL ends the string and returns the parser to its reset state.
    if (is_nul) begin
      phase_d = tuip_pkg::PH_SPACE;
      neg_d   = 1'b0;
      ovf_d   = 1'b0;
      acc_d   = '0;
      base_d  = tuip_pkg::BASE_AUTO;
      pos_d   = '0;
      stop_d  = '0;
      seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tuip_pkg::PH_SPACE;
      neg_q   <= 1'b0;
      ovf_q   <= 1'b0;
      acc_q   <= '0;
      base_q  <= tuip_pkg::BASE_AUTO;
      pos_q   <= '0;
      stop_q  <= '0;
      seen_q  <= 1'b0;
    end else if (fire) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      ovf_q   <= ovf_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      pos_q   <= pos_d;
      stop_q  <= stop_d;
      seen_q  <= seen_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result formation and output register.
  // ---------------------------------------------------------------------
  logic [WORD_BITS-1:0]     res_value;
  logic [SB-1:0]            res_stop;
  tuip_pkg::status_e        res_status;
  logic [INDEX_BITS+SB-1:0] stop_ext;

  // The stop index is reported modulo 2^16.
  assign stop_ext = (INDEX_BITS + SB)'(stop_q);

  always_comb begin
    res_value  = '0;
    res_stop   = '0;
    res_status = tuip_pkg::ST_OK;
    if (phase_eff == tuip_pkg::PH_BAD) begin
      res_status = tuip_pkg::ST_BAD_BASE;
    end else if (!seen_q) begin
      res_status = tuip_pkg::ST_NO_DIGITS;
    end else if (ovf_q) begin
      res_value  = '1;
      res_stop   = stop_ext[SB-1:0];
      res_status = tuip_pkg::ST_OVERFLOW;
    end else begin
      res_value  = neg_q ? WORD_BITS'(-acc_q) : acc_q;
      res_stop   = stop_ext[SB-1:0];
    end
  end

  logic out_load;
  assign out_load = fire && is_nul;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_o      <= res_value;
      stop_index_o <= res_stop;
      status_o     <= res_status;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------

  // A NUL transfer returns the parser to its start-of-string state.
  a_nul_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (phase_q == tuip_pkg::PH_SPACE) && (pos_q == '0) && !seen_q && !ovf_q)
    else $error("parse state not cleared after end of string");

  // Overflow and a stop index only exist once a digit has been taken.
  a_seen_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> !ovf_q && (stop_q == '0))
    else $error("overflow or stop index without digits");

  // A held byte that is not consumed stays in the input register.
  a_hold_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(char_q))
    else $error("stalled byte lost from input register");

  // Bad-base and no-digit results carry zero value and stop index.
  a_empty_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == tuip_pkg::ST_BAD_BASE) ||
                    (status_o == tuip_pkg::ST_NO_DIGITS))
      |-> (value_o == '0) && (stop_index_o == '0))
    else $error("empty conversion with nonzero value or index");

endmodule

`default_nettype wire
